FILE: src/lagrange_fractional_resampler_assert.svh
// Assertion macros for the resampler RTL.
// Included by lfr_ctrl, which checks its own control sequencing.
`ifndef LAGRANGE_FRACTIONAL_RESAMPLER_ASSERT_SVH
`define LAGRANGE_FRACTIONAL_RESAMPLER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LFR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("resampler check failed");

// Next-cycle implication, held off during reset.
`define LFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("resampler sequencing check failed");

`endif

FILE: src/lfr_pkg.sv
// Shared types and constants for the Lagrange fractional resampler.
// No dependencies.
`timescale 1ns / 1ps
package lfr_pkg;

    localparam int CFG_WIDTH    = 22;
    localparam int GAIN_WIDTH   = 16;
    localparam int GAIN_SHIFT   = 14;
    localparam int MAX_RESULTS  = 32;
    localparam int CNT_WIDTH    = 6;

    localparam logic [CFG_WIDTH-1:0]  RATIO_RESET = 22'd65536;
    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET  = 16'd16384;

    localparam logic REG_STEP_RATIO  = 1'b0;
    localparam logic REG_OUTPUT_GAIN = 1'b1;

    localparam logic [2:0] LAST_TAP = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_PROD,
        ST_DIVM,
        ST_DIVC,
        ST_MAC,
        ST_ROUND,
        ST_GAIN,
        ST_SAT
    } lfr_state_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       setup;
        logic       prod;
        logic       divm;
        logic       divc;
        logic       mac;
        logic       round;
        logic       gain;
        logic       emit;
        logic [2:0] j;
        logic [2:0] k;
    } lfr_cmd_t;

    typedef struct packed {
        logic pass_thru;
        logic step_due;
        logic out_free;
        logic last;
    } lfr_status_t;

endpackage

FILE: src/lagrange_fractional_resampler.sv
// Top level of the fractional-ratio Lagrange resampler.
// Depends on lfr_pkg, lfr_ctrl and lfr_datapath.
//
// Usage:
//   Input channel (s_valid / s_ready / s_in_sample) takes one signed sample
//   per transfer. Output channel (m_valid / m_ready / m_out_sample /
//   m_last_in_run) gives zero to 32 interpolated samples per input; the
//   final one caused by an input carries m_last_in_run.
//   Config: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0 = step_ratio, 1 = output_gain). Write only while the block is idle.
// Sequence:
//   An input transfer is followed, for each interpolated output, by step,
//   setup, 5 basis terms (each built from factor, divide and accumulate
//   states), round, gain and saturate; with nothing due the block goes
//   back to idle after its check. With a ratio of exactly one the sample
//   skips interpolation: it is scaled by the gain, saturated and presented.
// Reset: history clears to zero, phase to 1.0, ratio 1.0, gain unity.
// Stall: a finished result waits in the output register; s_ready returns
//   as soon as the last result of an input has been loaded into it.
`timescale 1ns / 1ps
module lagrange_fractional_resampler
    import lfr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [CFG_WIDTH-1:0]          cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_in_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    output logic                          m_last_in_run
);

    lfr_cmd_t    cmd;
    lfr_status_t status;

    // Sequencer: one output at a time, one factor per cycle.
    lfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, state and the output register.
    lfr_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_in_sample   (s_in_sample),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_sample  (m_out_sample),
        .m_last_in_run (m_last_in_run),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

FILE: src/lfr_datapath.sv
// Datapath of the resampler: config registers, history, phase, Lagrange
// arithmetic and output register. Depends on lfr_pkg.
`timescale 1ns / 1ps
module lfr_datapath
    import lfr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [CFG_WIDTH-1:0]          cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] s_in_sample,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    output logic                          m_last_in_run,
    input  lfr_cmd_t                      cmd,
    output lfr_status_t                   status
);

    localparam int SB   = SAMPLE_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PHW  = F + 7;
    localparam int PW   = F + 5;
    localparam int DW   = F + 3;
    localparam int AW   = F + 4;
    localparam int BW   = F + 3;
    localparam int ACCW = SB + F + 4;
    localparam int YW   = ACCW + 1 - F;
    localparam int GPW  = YW + GAIN_WIDTH;
    localparam int ZW   = GPW + 1 - GAIN_SHIFT;
    localparam int CW   = (CFG_WIDTH > PHW) ? CFG_WIDTH : PHW;
    localparam int PDW  = PW + DW;

    localparam logic [F:0]        ONE_X    = {1'b1, {F{1'b0}}};
    localparam logic [PHW-1:0]    ONE_PH   = PHW'(ONE_X);
    localparam logic [CW-1:0]     RATIO_LO = CW'(ONE_X) >> 5;
    localparam logic [CW-1:0]     RATIO_HI = CW'(ONE_X) << 5;
    localparam logic signed [DW-1:0] ONE_D = DW'(ONE_X);
    localparam logic signed [DW-1:0] TWO_D = DW'(ONE_X) << 1;
    localparam logic signed [PW-1:0] ONE_P = PW'(ONE_X);
    localparam logic signed [PDW:0]  HALF_PD = (PDW+1)'(ONE_X >> 1);
    localparam logic signed [ACCW:0] HALF_AC = (ACCW+1)'(ONE_X >> 1);
    localparam logic signed [GPW:0]  HALF_G  = (GPW+1)'(1 << (GAIN_SHIFT - 1));
    localparam longint unsigned DIV3_L = (64'd1 << (AW + 1)) / 3;
    localparam logic [AW:0] DIV3_M = (AW+1)'(DIV3_L);
    localparam logic signed [ZW-1:0] SMAX = {{(ZW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ZW-1:0] SMIN = {{(ZW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic [CFG_WIDTH-1:0]         ratio_cfg_reg;
    logic signed [GAIN_WIDTH-1:0] gain_reg;
    logic signed [SB-1:0]         hist_reg [5];
    logic [PHW-1:0]               phase_reg;
    logic [CNT_WIDTH-1:0]         cnt_reg;
    logic                         last_reg;
    logic [F:0]                   x_reg;
    logic signed [PW-1:0]         p_reg;
    logic [AW-1:0]                a_reg;
    logic [2*AW:0]                qp_reg;
    logic                         neg_reg;
    logic signed [BW-1:0]         basis_reg;
    logic signed [ACCW-1:0]       acc_reg;
    logic signed [YW-1:0]         y_reg;
    logic signed [GPW-1:0]        gp_reg;
    logic                         m_valid_reg;
    logic signed [SB-1:0]         out_reg;
    logic                         out_last_reg;

    logic [CW-1:0]          ratio_ext;
    logic [PHW-1:0]         ratio;
    logic [PHW:0]           ph_inc;
    logic [PHW-1:0]         ph_sub;
    logic signed [DW-1:0]   xs;
    logic signed [DW-1:0]   d_sel;
    logic signed [PDW-1:0]  pd_full;
    logic signed [PDW:0]    pd_rnd;
    logic [AW-1:0]          p_mag;
    logic [AW-1:0]          a_sum;
    logic [AW-1:0]          t_div;
    logic [AW-1:0]          t_c;
    logic [AW-1:0]          q0;
    logic [AW+1:0]          r3;
    logic [AW-1:0]          mag;
    logic signed [SB-1:0]   h_sel;
    logic signed [ACCW:0]   acc_rnd;
    logic signed [GPW:0]    g_rnd;
    logic signed [ZW-1:0]   z;

    // Clamp the ratio into its legal range.
    always_comb begin
        ratio_ext = CW'(ratio_cfg_reg);
        if (ratio_ext < RATIO_LO) begin
            ratio_ext = RATIO_LO;
        end else if (ratio_ext > RATIO_HI) begin
            ratio_ext = RATIO_HI;
        end
        ratio  = ratio_ext[PHW-1:0];
        ph_inc = {1'b0, phase_reg} + (PHW+1)'(ONE_PH);
        ph_sub = phase_reg - ratio;
    end

    // One Lagrange factor: p * d[j], rounded back to FRAC_BITS.
    always_comb begin
        xs = DW'(x_reg);
        case (cmd.j)
            3'd0:    d_sel = xs + TWO_D;
            3'd1:    d_sel = xs + ONE_D;
            3'd2:    d_sel = xs;
            3'd3:    d_sel = xs - ONE_D;
            default: d_sel = xs - TWO_D;
        endcase
        pd_full = p_reg * d_sel;
        pd_rnd  = ((PDW+1)'(pd_full) + (pd_full[PDW-1] ? HALF_PD - 1 : HALF_PD)) >>> F;
    end

    // Rounded division by the basis denominator (24, 6, 4, 6, 24).
    always_comb begin
        p_mag = p_reg[PW-1] ? AW'(-p_reg) : AW'(p_reg);
        case (cmd.k)
            3'd0, 3'd4: a_sum = p_mag + AW'(12);
            3'd2:       a_sum = p_mag + AW'(2);
            default:    a_sum = p_mag + AW'(3);
        endcase
        t_div = (cmd.k == 3'd0 || cmd.k == 3'd4) ? (a_sum >> 3) : (a_sum >> 1);
        t_c   = (cmd.k == 3'd0 || cmd.k == 3'd4) ? (a_reg >> 3) : (a_reg >> 1);
        q0    = qp_reg[2*AW:AW+1];
        r3    = (AW+2)'(t_c) - (AW+2)'(q0) * (AW+2)'(3);
        if (cmd.k == 3'd2) begin
            mag = a_reg >> 2;
        end else begin
            mag = q0 + AW'(r3 >= (AW+2)'(3));
        end
    end

    always_comb begin
        case (cmd.k)
            3'd0:    h_sel = hist_reg[4];
            3'd1:    h_sel = hist_reg[3];
            3'd2:    h_sel = hist_reg[2];
            3'd3:    h_sel = hist_reg[1];
            default: h_sel = hist_reg[0];
        endcase
        acc_rnd = ((ACCW+1)'(acc_reg) + (acc_reg[ACCW-1] ? HALF_AC - 1 : HALF_AC)) >>> F;
        g_rnd   = ((GPW+1)'(gp_reg) + (gp_reg[GPW-1] ? HALF_G - 1 : HALF_G)) >>> GAIN_SHIFT;
        z       = g_rnd[ZW-1:0];
    end

    // Control state: config, history, phase, counters, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_cfg_reg <= RATIO_RESET;
            gain_reg      <= GAIN_RESET;
            for (int i = 0; i < 5; i++) begin
                hist_reg[i] <= '0;
            end
            phase_reg    <= ONE_PH;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_RATIO:  ratio_cfg_reg <= cfg_wdata;
                    REG_OUTPUT_GAIN: gain_reg      <= cfg_wdata[GAIN_WIDTH-1:0];
                    default:         ratio_cfg_reg <= ratio_cfg_reg;
                endcase
            end
            if (cmd.load) begin
                for (int i = 4; i > 0; i--) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= s_in_sample;
                cnt_reg     <= '0;
                if (ratio == ONE_PH) begin
                    last_reg <= 1'b1;
                end else begin
                    phase_reg <= ph_inc[PHW] ? {PHW{1'b1}} : ph_inc[PHW-1:0];
                end
            end
            if (cmd.step) begin
                phase_reg <= ph_sub;
                cnt_reg   <= cnt_reg + 1'b1;
                last_reg  <= (cnt_reg == CNT_WIDTH'(MAX_RESULTS - 1)) || (ph_sub < ratio);
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Arithmetic registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            y_reg <= YW'(s_in_sample);
        end
        if (cmd.setup) begin
            x_reg   <= (phase_reg < ONE_PH) ? (ONE_X - (F+1)'(phase_reg)) : '0;
            acc_reg <= '0;
            p_reg   <= ONE_P;
        end
        if (cmd.prod) begin
            p_reg <= pd_rnd[PW-1:0];
        end
        if (cmd.divm) begin
            a_reg   <= a_sum;
            qp_reg  <= t_div * DIV3_M;
            neg_reg <= p_reg[PW-1] ^ (cmd.k == 3'd1 || cmd.k == 3'd3);
        end
        if (cmd.divc) begin
            basis_reg <= neg_reg ? -BW'(mag) : BW'(mag);
        end
        if (cmd.mac) begin
            acc_reg <= acc_reg + ACCW'(h_sel * basis_reg);
            p_reg   <= ONE_P;
        end
        if (cmd.round) begin
            y_reg <= acc_rnd[YW-1:0];
        end
        if (cmd.gain) begin
            gp_reg <= y_reg * gain_reg;
        end
        if (cmd.emit) begin
            out_last_reg <= last_reg;
            if (z > SMAX) begin
                out_reg <= SMAX[SB-1:0];
            end else if (z < SMIN) begin
                out_reg <= SMIN[SB-1:0];
            end else begin
                out_reg <= z[SB-1:0];
            end
        end
    end

    assign status.pass_thru = (ratio == ONE_PH);
    assign status.step_due  = (phase_reg >= ratio) && (cnt_reg != CNT_WIDTH'(MAX_RESULTS));
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.last      = last_reg;

    assign m_valid       = m_valid_reg;
    assign m_out_sample  = out_reg;
    assign m_last_in_run = out_last_reg;

endmodule

FILE: src/lfr_ctrl.sv
// Sequencer of the resampler: walks outputs, basis terms and factors.
// Depends on lfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lagrange_fractional_resampler_assert.svh"
module lfr_ctrl
    import lfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lfr_status_t status,
    output lfr_cmd_t    cmd
);

    lfr_state_t state_reg, state_next;
    logic [2:0] j_reg, j_next;
    logic [2:0] k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.j      = j_reg;
        cmd.k      = k_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.pass_thru ? ST_GAIN : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.step_due) begin
                    cmd.step   = 1'b1;
                    state_next = ST_SETUP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                j_next     = '0;
                k_next     = '0;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod = (j_reg != k_reg);
                if (j_reg == LAST_TAP) begin
                    j_next     = '0;
                    state_next = ST_DIVM;
                end else begin
                    j_next = j_reg + 3'd1;
                end
            end
            ST_DIVM: begin
                cmd.divm   = 1'b1;
                state_next = ST_DIVC;
            end
            ST_DIVC: begin
                cmd.divc   = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac = 1'b1;
                if (k_reg == LAST_TAP) begin
                    k_next     = '0;
                    state_next = ST_ROUND;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_PROD;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.last ? ST_IDLE : ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LFR_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, (state_reg == ST_SAT && status.out_free && status.last), (state_reg == ST_IDLE))
    `LFR_ASSERT_IMPLY(a_tap_range, aclk, aresetn, (state_reg == ST_PROD), (j_reg <= LAST_TAP && k_reg <= LAST_TAP))
    `LFR_ASSERT_NEXT(a_mac_done, aclk, aresetn, (state_reg == ST_MAC && k_reg == LAST_TAP), (state_reg == ST_ROUND))

endmodule

FILE: tb/sv/lagrange_fractional_resampler_test.sv
// Self-checking testbench for the Lagrange fractional resampler.
// Depends on lfr_pkg and lagrange_fractional_resampler; predicts each output sample in place.
`timescale 1ns / 1ps
module lagrange_fractional_resampler_test;
    import lfr_pkg::*;

    localparam int  SBITS      = 24;
    localparam int  FBITS      = 16;
    localparam longint ONE_Q   = 64'sd1 << FBITS;
    localparam longint PH_MAX  = (64'sd1 << (FBITS + 7)) - 1;
    localparam longint S_HI    = (64'sd1 << (SBITS - 1)) - 1;
    localparam longint S_LO    = -S_HI - 1;
    // Hard limit on the run, with slack over the longest run including receiver stalls.
    localparam int  CYCLE_LIMIT = 2_500_000;
    localparam int  SETTLE      = 120;

    typedef struct {
        logic signed [SBITS-1:0] sample;
        logic                    last;
    } out_item_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic                    cfg_index;
    logic [CFG_WIDTH-1:0]    cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [SBITS-1:0] s_in_sample;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [SBITS-1:0] m_out_sample;
    logic                    m_last_in_run;

    // Predictor state: tap history (newest at 0), phase, and register copies.
    longint                  taps[5];
    longint                  phase_acc;
    logic [CFG_WIDTH-1:0]    ratio_reg;
    logic [GAIN_WIDTH-1:0]   gain_reg;

    out_item_t               pending_outputs[$];
    int                      error_count;
    bit                      quiet;
    int                      cycle_count;

    lagrange_fractional_resampler #(
        .SAMPLE_BITS (SBITS),
        .FRAC_BITS   (FBITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_sample   (s_in_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_sample  (m_out_sample),
        .m_last_in_run (m_last_in_run)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Round to nearest, ties away from zero, on the magnitude.
    function automatic longint round_shr(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 << (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint round_quot(longint v, longint d);
        longint m;
        longint q;
        bit     neg;
        neg = (v < 0) != (d < 0);
        m = (v < 0) ? -v : v;
        q = (d < 0) ? -d : d;
        m = (m + q / 2) / q;
        return neg ? -m : m;
    endfunction

    // Apply gain in Q2.14 and saturate to the sample width.
    function automatic logic signed [SBITS-1:0] gain_saturate(longint y);
        longint g;
        longint z;
        g = longint'($signed(gain_reg));
        z = round_shr(y * g, GAIN_SHIFT);
        if (z > S_HI) z = S_HI;
        if (z < S_LO) z = S_LO;
        return z[SBITS-1:0];
    endfunction

    // Five-point Lagrange value at offset x past the middle tap.
    function automatic longint interpolate_at(longint x);
        longint offs[5];
        longint den[5];
        longint acc;
        longint p;
        den = '{24, -6, 4, -6, 24};
        acc = 0;
        for (int j = 0; j < 5; j++) offs[j] = x - longint'(j - 2) * ONE_Q;
        for (int k = 0; k < 5; k++) begin
            p = ONE_Q;
            for (int j = 0; j < 5; j++)
                if (j != k) p = round_shr(p * offs[j], FBITS);
            acc += taps[4 - k] * round_quot(p, den[k]);
        end
        return round_shr(acc, FBITS);
    endfunction

    // Advance the predictor by one accepted sample and queue its outputs.
    task automatic predict_outputs(logic signed [SBITS-1:0] smp);
        longint    ratio;
        longint    x;
        int        n;
        out_item_t item;
        ratio = longint'(ratio_reg);
        if (ratio < ONE_Q / 32) ratio = ONE_Q / 32;
        if (ratio > ONE_Q * 32) ratio = ONE_Q * 32;
        for (int i = 4; i > 0; i--) taps[i] = taps[i - 1];
        taps[0] = longint'(smp);
        if (ratio == ONE_Q) begin
            item.sample = gain_saturate(longint'(smp));
            item.last   = 1'b1;
            pending_outputs.push_back(item);
            return;
        end
        phase_acc += ONE_Q;
        if (phase_acc > PH_MAX) phase_acc = PH_MAX;
        n = 0;
        while (n < MAX_RESULTS && phase_acc >= ratio) begin
            phase_acc -= ratio;
            x = ONE_Q - phase_acc;
            if (x < 0) x = 0;
            item.sample = gain_saturate(interpolate_at(x));
            n++;
            item.last = !(n < MAX_RESULTS && phase_acc >= ratio);
            pending_outputs.push_back(item);
        end
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic idx, logic [CFG_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_STEP_RATIO) ratio_reg = value;
        else gain_reg = value[GAIN_WIDTH-1:0];
    endtask

    task automatic write_gain(int g);
        logic [GAIN_WIDTH-1:0] gv;
        gv = g[GAIN_WIDTH-1:0];
        write_reg(REG_OUTPUT_GAIN, CFG_WIDTH'(gv));
    endtask

    // Offer one sample, with an optional idle burst first; return on its transfer.
    task automatic send_sample(logic signed [SBITS-1:0] smp);
        @(negedge aclk);
        if (!quiet && $urandom_range(3, 0) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_in_sample = smp;
        do @(posedge aclk); while (!s_ready);
        predict_outputs(smp);
    endtask

    // Drop valid, wait for every queued output, then let the block settle.
    task automatic drain_outputs();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic signed [SBITS-1:0] rand_sample();
        case ($urandom_range(3, 0))
            0:       return SBITS'($urandom_range(2000, 0)) - SBITS'(1000);
            default: return SBITS'($urandom);
        endcase
    endfunction

    // Smallest ratio straight after reset: the reset phase leaves more than
    // 32 outputs due, so the surplus stays pending across inputs.
    task automatic test_min_ratio();
        write_reg(REG_STEP_RATIO, 22'd2048);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd1234567);
        drain_outputs();
    endtask

    // Out-of-range ratios clamp to 1/32 and to 32.
    task automatic test_ratio_clamp();
        write_reg(REG_STEP_RATIO, 22'd0);
        send_sample(24'sd0);
        drain_outputs();
        write_reg(REG_STEP_RATIO, 22'h3FFFFF);
        for (int i = 0; i < 4; i++) send_sample(rand_sample());
        drain_outputs();
    endtask

    // Unity ratio passes samples through; exercise gain extremes and saturation.
    task automatic test_pass_through_gain();
        int gains[4];
        gains = '{32767, -32768, 0, 16384};
        write_reg(REG_STEP_RATIO, 22'd65536);
        foreach (gains[g]) begin
            write_gain(gains[g]);
            send_sample(24'sd8388607);
            send_sample(-24'sd8388608);
            send_sample(-24'sd1);
            drain_outputs();
        end
    endtask

    // Random ratios, gains and samples, mostly near unity so runs stay short.
    task automatic test_random_ratios();
        int ratio;
        int count;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(5, 0))
                0: begin ratio = 65536;                        count = 30; end
                1: begin ratio = $urandom_range(32767, 2048);  count = 8;  end
                2: begin ratio = $urandom_range(2097152, 262144); count = 40; end
                default: begin ratio = $urandom_range(262144, 32768); count = 30; end
            endcase
            write_reg(REG_STEP_RATIO, CFG_WIDTH'(ratio));
            write_gain(($urandom_range(1, 0) == 0) ? 16384 : int'($urandom_range(65535, 0)) - 32768);
            repeat (count) send_sample(rand_sample());
            drain_outputs();
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_quiet_tail();
        quiet = 1'b1;
        write_reg(REG_STEP_RATIO, 22'd49152);
        write_gain(20000);
        repeat (50) send_sample(rand_sample());
        drain_outputs();
    endtask

    // Receiver side: random stall bursts, none once the tail starts.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(4, 0) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(8, 1)) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(12, 1)) @(negedge aclk);
        end
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output sample %0d last %0b",
                         $time, m_out_sample, m_last_in_run);
                error_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_out_sample !== want.sample) begin
                    $display("%0t: out_sample expected %0d actual %0d",
                             $time, want.sample, m_out_sample);
                    error_count++;
                end
                if (m_last_in_run !== want.last) begin
                    $display("%0t: last_in_run expected %0b actual %0b",
                             $time, want.last, m_last_in_run);
                    error_count++;
                end
            end
        end
    end

    // Hold a hard limit on run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("lagrange_fractional_resampler: mismatch");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_STEP_RATIO;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_in_sample = '0;
        quiet       = 1'b0;
        error_count = 0;
        for (int i = 0; i < 5; i++) taps[i] = 0;
        phase_acc = ONE_Q;
        ratio_reg = RATIO_RESET;
        gain_reg  = GAIN_RESET;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        test_min_ratio();
        test_ratio_clamp();
        test_pass_through_gain();
        test_random_ratios();
        test_quiet_tail();

        if (error_count == 0)
            $display("lagrange_fractional_resampler: match");
        else
            $display("lagrange_fractional_resampler: mismatch");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/lfr_pkg.sv
src/lfr_datapath.sv
src/lfr_ctrl.sv
src/lagrange_fractional_resampler.sv
tb/sv/lagrange_fractional_resampler_test.sv
